>>> sv/tcch_pkg.sv
// tcch_pkg: widths, constants and cordic angle table for the compass heading core
// no dependencies; imported by the core and its checker

package tcch_pkg;

   // field widths
   localparam int ACCEL_W   = 17;
   localparam int MAG_W     = 16;
   localparam int DECL_W    = 15;
   localparam int HEADING_W = 17;
   localparam int TILT_W    = 22;
   localparam int CSR_IDX_W = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DECLINATION   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_PRESENT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAG_PRESENT   = 2'd2;

   // fixed point setup
   localparam int FRAC_BITS    = 12;
   localparam int CORDIC_STEPS = 16;
   localparam int ANG_W        = FRAC_BITS + 4;
   localparam int CI_W         = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

   // shared multiplier and datapath widths
   localparam int MA_W   = 36;
   localparam int MB_W   = (ANG_W > 19) ? ANG_W : 19;
   localparam int P_W    = MA_W + MB_W;
   localparam int ACC_W  = P_W + 1;
   localparam int CX_W   = 56;
   localparam int SQ_W   = 36;
   localparam int ROOT_W = 18;
   localparam int HSUM_W = 20;

   // constants
   localparam longint PI_Q30            = 64'sd3373259426;
   localparam longint TWO_PI_Q24        = 64'sd105414357;
   localparam longint DEG64_PER_RAD_Q20 = 64'sd3845054675;
   localparam int     FULL_TURN_DEG64   = 23040;
   localparam int     NO_MAG_HEADING    = 25600;
   localparam int     TILT_RESET        = 1638400;
   localparam int     SQ_TOP_BIT        = 34;

   localparam longint PI_ANG = (PI_Q30 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);

   localparam longint ATAN_TAB [32] = '{
      843314857, 497837829, 263043837, 133525159, 67021687,
      33543516, 16775851, 8388437, 4194283, 2097149,
      1048576, 524288, 262144, 131072, 65536, 32768,
      16384, 8192, 4096, 2048, 1024, 512, 256, 128,
      64, 32, 16, 8, 4, 2, 1, 0
   };

   // arctan(2^-i) in radians, FRAC_BITS fraction bits, rounded half up
   function automatic logic signed [ANG_W-1:0] cordic_angle(input logic [CI_W-1:0] idx);
      longint v;
      v = (ATAN_TAB[idx] + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
      return ANG_W'(v);
   endfunction

endpackage

>>> sv/tilt_compensated_compass_heading_core.sv
// tilt_compensated_compass_heading_core: sequenced fixed point compass heading
// depends on tcch_pkg
//
// usage
//   req_* carries one beat: accelerometer triple (1/4096 g) and magnetometer
//   triple. rsp_* returns one beat per request: heading in 1/64 degree plus
//   declination, and the held tilt (roll times two pi, 1/4096).
//   csr_* writes declination, accel_present and mag_present; write only
//   while the core is idle.
// timing
//   one request at a time; req_stall is high from acceptance until the
//   response beat is taken. with no magnetometer rsp_valid rises in the
//   cycle after the request beat. the plain path runs one cordic on the
//   raw field, skipping normalize and iterations for a zero field vector.
//   each cordic run normalizes its input vector, then adds CORDIC_STEPS
//   iterations. the tilt path first spends 3 square steps, two square
//   roots and 9 projection steps, then runs a tilt cordic and a heading
//   cordic, 14 passes through the one shared multiplier in all.
//   a new request can be taken in the cycle after the response beat.
//   the response stays on rsp_* while rsp_stall is high.
// reset
//   synchronous: core idle, control registers cleared, held tilt back to 400.0.

module tilt_compensated_compass_heading_core (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [tcch_pkg::ACCEL_W-1:0]     req_accel_x,
   input  logic signed [tcch_pkg::ACCEL_W-1:0]     req_accel_y,
   input  logic signed [tcch_pkg::ACCEL_W-1:0]     req_accel_z,
   input  logic signed [tcch_pkg::MAG_W-1:0]       req_mag_x,
   input  logic signed [tcch_pkg::MAG_W-1:0]       req_mag_y,
   input  logic signed [tcch_pkg::MAG_W-1:0]       req_mag_z,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [tcch_pkg::HEADING_W-1:0]   rsp_heading,
   output logic signed [tcch_pkg::TILT_W-1:0]      rsp_tilt,
   input  logic                                    csr_wr_en,
   input  logic [tcch_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [tcch_pkg::DECL_W-1:0]             csr_wdata
);
   import tcch_pkg::*;

   typedef enum logic [21:0] {
      S_IDLE    = 22'h000001,
      S_SQ1     = 22'h000002,
      S_SQ2     = 22'h000004,
      S_SQ3     = 22'h000008,
      S_ROOT    = 22'h000010,
      S_H1      = 22'h000020,
      S_H2      = 22'h000040,
      S_H3      = 22'h000080,
      S_H4      = 22'h000100,
      S_H5      = 22'h000200,
      S_H6      = 22'h000400,
      S_H7      = 22'h000800,
      S_H8      = 22'h001000,
      S_H9      = 22'h002000,
      S_C_START = 22'h004000,
      S_C_NORM  = 22'h008000,
      S_C_ITER  = 22'h010000,
      S_TILT    = 22'h020000,
      S_HDG     = 22'h040000,
      S_OUT     = 22'h080000,
      S_SPARE0  = 22'h100000,
      S_SPARE1  = 22'h200000
   } state_type;

   // control registers
   state_type                  state_ff, state_in;
   logic signed [DECL_W-1:0]   decl_ff, decl_in;
   logic                       accel_en_ff, accel_en_in;
   logic                       mag_en_ff, mag_en_in;
   logic signed [TILT_W-1:0]   held_tilt_ff, held_tilt_in;
   logic                       root_g_ff, root_g_in;
   logic                       sel_hdg_ff, sel_hdg_in;

   // payload registers
   logic signed [ACCEL_W-1:0]  ax_ff, ax_in, ay_ff, ay_in, az_ff, az_in;
   logic signed [MAG_W-1:0]    mx_ff, mx_in, my_ff, my_in, mz_ff, mz_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [MA_W-1:0]     tmp_ff, tmp_in;
   logic signed [CX_W-1:0]     hx_ff, hx_in;
   logic [SQ_W-1:0]            sq_v_ff, sq_v_in, sq_res_ff, sq_res_in, sq_bit_ff, sq_bit_in;
   logic [ROOT_W-1:0]          r_ff, r_in, g_ff, g_in;
   logic signed [CX_W-1:0]     cx_ff, cx_in, cy_ff, cy_in;
   logic signed [ANG_W-1:0]    cz_ff, cz_in;
   logic [CI_W-1:0]            ci_ff, ci_in;
   logic signed [HEADING_W-1:0] hdg_ff, hdg_in;

   // shared multiplier and helpers
   logic signed [MA_W-1:0]     mul_a;
   logic signed [MB_W-1:0]     mul_b;
   logic signed [P_W-1:0]      prod;
   logic signed [P_W-1:0]      prod_rnd;
   logic signed [ACCEL_W:0]    az_wide;
   logic [ACCEL_W:0]           aza;
   logic                       r_zero;
   logic [SQ_W-1:0]            sq_trial;
   logic [SQ_W-1:0]            sq_round;
   logic signed [CX_W-1:0]     cy_abs;
   logic [CX_W-1:0]            big;
   logic signed [CX_W-1:0]     cx_sh, cy_sh;
   logic signed [HSUM_W-1:0]   hsum;
   logic                       req_fire, rsp_fire;

   assign req_fire = req_valid && !req_stall;
   assign rsp_fire = rsp_valid && !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_heading = hdg_ff;
   assign rsp_tilt = held_tilt_ff;

   assign az_wide = (ACCEL_W+1)'(az_ff);
   assign aza = (az_wide < 0) ? (ACCEL_W+1)'(-az_wide) : (ACCEL_W+1)'(az_wide);
   assign r_zero = (r_ff == '0);

   // operand selection for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_SQ1: begin mul_a = MA_W'(ay_ff); mul_b = MB_W'(ay_ff); end
         S_SQ2: begin mul_a = MA_W'(az_ff); mul_b = MB_W'(az_ff); end
         S_SQ3: begin mul_a = MA_W'(ax_ff); mul_b = MB_W'(ax_ff); end
         S_H1:  begin mul_a = MA_W'(mx_ff); mul_b = MB_W'(r_ff); end
         S_H2:  begin mul_a = MA_W'(mz_ff); mul_b = MB_W'(ax_ff); end
         S_H3:  begin mul_a = tmp_ff;       mul_b = MB_W'(r_ff); end
         S_H4:  begin mul_a = MA_W'(mx_ff); mul_b = MB_W'(ax_ff); end
         S_H5:  begin mul_a = tmp_ff;       mul_b = MB_W'(ay_ff); end
         S_H6:  begin mul_a = MA_W'(my_ff); mul_b = MB_W'(aza); end
         S_H7:  begin mul_a = tmp_ff;       mul_b = MB_W'(g_ff); end
         S_H8:  begin mul_a = MA_W'(mz_ff); mul_b = MB_W'(ay_ff); end
         S_H9:  begin mul_a = tmp_ff;       mul_b = MB_W'(r_ff); end
         S_TILT: begin mul_a = MA_W'(TWO_PI_Q24); mul_b = MB_W'(cz_ff); end
         S_HDG: begin mul_a = MA_W'(DEG64_PER_RAD_Q20); mul_b = MB_W'(cz_ff); end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   assign prod = P_W'(mul_a) * P_W'(mul_b);

   // round half up before the final scaling shift
   always_comb begin
      if (state_ff == S_TILT) begin
         prod_rnd = (prod + (P_W'(1) <<< (FRAC_BITS + 11))) >>> (FRAC_BITS + 12);
      end else begin
         prod_rnd = (prod + (P_W'(1) <<< (FRAC_BITS + 19))) >>> (FRAC_BITS + 20);
      end
   end

   // square root step helpers
   assign sq_trial = sq_res_ff + sq_bit_ff;
   assign sq_round = (sq_v_ff > sq_res_ff) ? sq_res_ff + SQ_W'(1) : sq_res_ff;

   // cordic helpers
   assign cy_abs = (cy_ff < 0) ? -cy_ff : cy_ff;
   assign big = cx_ff | cy_abs;
   assign cx_sh = cx_ff >>> ci_ff;
   assign cy_sh = cy_ff >>> ci_ff;
   assign hsum = HSUM_W'(prod_rnd) + HSUM_W'(decl_ff);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      decl_in      = decl_ff;
      accel_en_in  = accel_en_ff;
      mag_en_in    = mag_en_ff;
      held_tilt_in = held_tilt_ff;
      root_g_in    = root_g_ff;
      sel_hdg_in   = sel_hdg_ff;
      ax_in = ax_ff; ay_in = ay_ff; az_in = az_ff;
      mx_in = mx_ff; my_in = my_ff; mz_in = mz_ff;
      acc_in = acc_ff;
      tmp_in = tmp_ff;
      hx_in  = hx_ff;
      sq_v_in = sq_v_ff; sq_res_in = sq_res_ff; sq_bit_in = sq_bit_ff;
      r_in = r_ff; g_in = g_ff;
      cx_in = cx_ff; cy_in = cy_ff; cz_in = cz_ff; ci_in = ci_ff;
      hdg_in = hdg_ff;

      // register writes
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DECLINATION:   decl_in = csr_wdata;
            CSR_ACCEL_PRESENT: accel_en_in = csr_wdata[0];
            CSR_MAG_PRESENT:   mag_en_in = csr_wdata[0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               ax_in = req_accel_x; ay_in = req_accel_y; az_in = req_accel_z;
               mx_in = req_mag_x; my_in = req_mag_y; mz_in = req_mag_z;
               if (!mag_en_ff) begin
                  hdg_in = HEADING_W'(NO_MAG_HEADING);
                  state_in = S_OUT;
               end else if (accel_en_ff && (req_accel_x != '0 || req_accel_y != '0)) begin
                  state_in = S_SQ1;
               end else begin
                  cx_in = CX_W'(req_mag_x);
                  cy_in = CX_W'(req_mag_y);
                  sel_hdg_in = 1'b1;
                  state_in = S_C_START;
               end
            end
         end
         // squares of the acceleration
         S_SQ1: begin
            acc_in = ACC_W'(prod);
            state_in = S_SQ2;
         end
         S_SQ2: begin
            acc_in = acc_ff + ACC_W'(prod);
            state_in = S_SQ3;
         end
         S_SQ3: begin
            sq_v_in = acc_ff[SQ_W-1:0];
            sq_res_in = '0;
            sq_bit_in = SQ_W'(1) << SQ_TOP_BIT;
            root_g_in = 1'b0;
            acc_in = acc_ff + ACC_W'(prod);
            state_in = S_ROOT;
         end
         // integer square root, one bit pair per cycle, rounded to nearest
         S_ROOT: begin
            if (sq_bit_ff == '0) begin
               if (!root_g_ff) begin
                  r_in = ROOT_W'(sq_round);
                  sq_v_in = acc_ff[SQ_W-1:0];
                  sq_res_in = '0;
                  sq_bit_in = SQ_W'(1) << SQ_TOP_BIT;
                  root_g_in = 1'b1;
               end else begin
                  g_in = ROOT_W'(sq_round);
                  state_in = S_H1;
               end
            end else begin
               if (sq_v_ff >= sq_trial) begin
                  sq_v_in = sq_v_ff - sq_trial;
                  sq_res_in = (sq_res_ff >> 1) + sq_bit_ff;
               end else begin
                  sq_res_in = sq_res_ff >> 1;
               end
               sq_bit_in = sq_bit_ff >> 2;
            end
         end
         // horizontal field components
         S_H1: begin
            acc_in = ACC_W'(prod);
            state_in = S_H2;
         end
         S_H2: begin
            tmp_in = MA_W'(acc_ff - ACC_W'(prod));
            state_in = S_H3;
         end
         S_H3: begin
            hx_in = r_zero ? CX_W'(tmp_ff) : CX_W'(prod);
            state_in = S_H4;
         end
         S_H4: begin
            tmp_in = MA_W'(prod);
            state_in = S_H5;
         end
         S_H5: begin
            acc_in = -ACC_W'(prod);
            state_in = S_H6;
         end
         S_H6: begin
            tmp_in = r_zero ? MA_W'(my_ff) : MA_W'(prod);
            state_in = S_H7;
         end
         S_H7: begin
            acc_in = acc_ff + ACC_W'(prod);
            state_in = S_H8;
         end
         S_H8: begin
            tmp_in = MA_W'(prod);
            state_in = S_H9;
         end
         S_H9: begin
            acc_in = acc_ff - ACC_W'(prod);
            cx_in = CX_W'(aza);
            cy_in = CX_W'(ay_ff);
            sel_hdg_in = 1'b0;
            state_in = S_C_START;
         end
         // cordic atan2: quadrant fold
         S_C_START: begin
            ci_in = '0;
            if (cx_ff == '0 && cy_ff == '0) begin
               cz_in = '0;
               state_in = sel_hdg_ff ? S_HDG : S_TILT;
            end else if (cx_ff < 0) begin
               cz_in = (cy_ff < 0) ? -ANG_W'(PI_ANG) : ANG_W'(PI_ANG);
               cx_in = -cx_ff;
               cy_in = -cy_ff;
               state_in = S_C_NORM;
            end else begin
               cz_in = '0;
               state_in = S_C_NORM;
            end
         end
         // cordic atan2: scale up until the larger coordinate reaches bit 48
         S_C_NORM: begin
            if (big < (CX_W'(1) << 40)) begin
               cx_in = cx_ff <<< 8;
               cy_in = cy_ff <<< 8;
            end else if (big < (CX_W'(1) << 48)) begin
               cx_in = cx_ff <<< 1;
               cy_in = cy_ff <<< 1;
            end else begin
               state_in = S_C_ITER;
            end
         end
         // cordic atan2: vectoring iterations
         S_C_ITER: begin
            if (cy_ff < 0) begin
               cx_in = cx_ff - cy_sh;
               cy_in = cy_ff + cx_sh;
               cz_in = cz_ff - cordic_angle(ci_ff);
            end else begin
               cx_in = cx_ff + cy_sh;
               cy_in = cy_ff - cx_sh;
               cz_in = cz_ff + cordic_angle(ci_ff);
            end
            ci_in = ci_ff + CI_W'(1);
            if (ci_ff == CI_W'(CORDIC_STEPS - 1)) begin
               state_in = sel_hdg_ff ? S_HDG : S_TILT;
            end
         end
         // held tilt from roll, then heading cordic on the projected field
         S_TILT: begin
            held_tilt_in = TILT_W'(prod_rnd);
            cx_in = hx_ff;
            cy_in = CX_W'(acc_ff);
            sel_hdg_in = 1'b1;
            state_in = S_C_START;
         end
         // degrees, declination and wrap
         S_HDG: begin
            if (hsum < 0) begin
               hdg_in = HEADING_W'(hsum + HSUM_W'(FULL_TURN_DEG64));
            end else begin
               hdg_in = HEADING_W'(hsum);
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_fire) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         decl_ff      <= '0;
         accel_en_ff  <= 1'b0;
         mag_en_ff    <= 1'b0;
         held_tilt_ff <= TILT_W'(TILT_RESET);
         root_g_ff    <= 1'b0;
         sel_hdg_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         decl_ff      <= decl_in;
         accel_en_ff  <= accel_en_in;
         mag_en_ff    <= mag_en_in;
         held_tilt_ff <= held_tilt_in;
         root_g_ff    <= root_g_in;
         sel_hdg_ff   <= sel_hdg_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      ax_ff <= ax_in; ay_ff <= ay_in; az_ff <= az_in;
      mx_ff <= mx_in; my_ff <= my_in; mz_ff <= mz_in;
      acc_ff <= acc_in;
      tmp_ff <= tmp_in;
      hx_ff  <= hx_in;
      sq_v_ff <= sq_v_in; sq_res_ff <= sq_res_in; sq_bit_ff <= sq_bit_in;
      r_ff <= r_in; g_ff <= g_in;
      cx_ff <= cx_in; cy_ff <= cy_in; cz_ff <= cz_in; ci_ff <= ci_in;
      hdg_ff <= hdg_in;
   end

endmodule

>>> sv/tcch_checker.sv
// tcch_checker: port level checks for the compass heading core
// depends on tcch_pkg; bound to tilt_compensated_compass_heading_core

module tcch_checker (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    req_valid,
   input logic                                    req_stall,
   input logic                                    rsp_valid,
   input logic                                    rsp_stall,
   input logic signed [tcch_pkg::HEADING_W-1:0]   rsp_heading,
   input logic signed [tcch_pkg::TILT_W-1:0]      rsp_tilt
);
   import tcch_pkg::*;

   // an accepted request makes the core busy
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("core not busy after request beat");

   // no new request while a response is pending
   a_busy_with_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while response pending");

   // one response per request
   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) |=> !rsp_valid)
      else $error("response repeated");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_heading) && $stable(rsp_tilt)))
      else $error("stalled response changed");

endmodule

bind tilt_compensated_compass_heading_core tcch_checker u_tcch_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_heading (rsp_heading),
   .rsp_tilt    (rsp_tilt)
);

>>> test/tilt_compensated_compass_heading_core_tb.sv
// testbench for the tilt compensated compass heading core: bit exact predictor
// with beat scoreboard, bursty sender and stalling receiver; depends on tcch_pkg
`timescale 1ns / 100ps

module tilt_compensated_compass_heading_core_tb;
   import tcch_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE_CYCLES = 150;

   typedef struct {
      logic signed [ACCEL_W-1:0] ax, ay, az;
      logic signed [MAG_W-1:0]   mx, my, mz;
   } sensor_beat_type;

   typedef struct {
      logic [HEADING_W-1:0] heading;
      logic [TILT_W-1:0]    tilt;
   } heading_beat_type;

   // heading predictor and store of expected response beats
   class heading_scoreboard;
      heading_beat_type expected_q[$];
      longint decl;
      bit accel_en, mag_en;
      longint held_tilt;
      int errors, checked;

      function new();
         decl = 0; accel_en = 0; mag_en = 0; held_tilt = TILT_RESET;
         errors = 0; checked = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [DECL_W-1:0] val);
         case (idx)
            CSR_DECLINATION:   decl = longint'($signed(val));
            CSR_ACCEL_PRESENT: accel_en = val[0];
            CSR_MAG_PRESENT:   mag_en = val[0];
            default: ;
         endcase
      endfunction

      function longint round_shift(longint v, int s);
         return (v + (64'sd1 <<< (s - 1))) >>> s;
      endfunction

      function longint int_sqrt(longint unsigned v);
         longint unsigned res, b;
         res = 0;
         b = 64'd1 << 62;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= res + b) begin
               v = v - (res + b);
               res = (res >> 1) + b;
            end else begin
               res = res >> 1;
            end
            b = b >> 2;
         end
         if (v > res) res++;
         return longint'(res);
      endfunction

      // vectoring rotation, angle in radians with FRAC_BITS fraction bits
      function longint vector_angle(longint y, longint x);
         longint z, xs, ys, pi_ang, step;
         longint unsigned mag;
         z = 0;
         pi_ang = round_shift(PI_Q30, 30 - FRAC_BITS);
         if (x == 0 && y == 0) return 0;
         if (x < 0) begin
            z = (y < 0) ? -pi_ang : pi_ang;
            x = -x;
            y = -y;
         end
         mag = longint'(x) | ((y < 0) ? -y : y);
         while (mag < (64'd1 << 48)) begin
            mag = mag << 1;
            x = x * 2;
            y = y * 2;
         end
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            step = round_shift(ATAN_TAB[i], 30 - FRAC_BITS);
            if (y < 0) begin
               x = x - ys; y = y + xs; z = z - step;
            end else begin
               x = x + ys; y = y - xs; z = z + step;
            end
         end
         return z;
      endfunction

      // accepted request beat: work out the response it must produce
      function void note_request(sensor_beat_type s);
         longint ax, ay, az, mx, my, mz, aza, r, g, hx, hy, ang, hdg;
         longint unsigned s2;
         heading_beat_type e;
         ax = s.ax; ay = s.ay; az = s.az; mx = s.mx; my = s.my; mz = s.mz;
         if (!mag_en) begin
            hdg = NO_MAG_HEADING;
         end else begin
            if (accel_en && (ax != 0 || ay != 0)) begin
               aza = (az < 0) ? -az : az;
               s2 = ay * ay + az * az;
               r = int_sqrt(s2);
               g = int_sqrt(s2 + ax * ax);
               if (r == 0) begin
                  hx = -mz * ax;
                  hy = my * g;
               end else begin
                  hx = (mx * r - mz * ax) * r;
                  hy = -mx * ax * ay + my * aza * g - mz * ay * r;
               end
               held_tilt = round_shift(vector_angle(ay, aza) * TWO_PI_Q24, FRAC_BITS + 12);
               ang = vector_angle(hy, hx);
            end else begin
               ang = vector_angle(my, mx);
            end
            hdg = round_shift(ang * DEG64_PER_RAD_Q20, FRAC_BITS + 20) + decl;
            if (hdg < 0) hdg += FULL_TURN_DEG64;
         end
         e.heading = hdg[HEADING_W-1:0];
         e.tilt = held_tilt[TILT_W-1:0];
         expected_q.push_back(e);
      endfunction

      task report(string msg);
         $display("ERROR @%0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_response(logic [HEADING_W-1:0] h, logic [TILT_W-1:0] t);
         heading_beat_type e;
         checked++;
         if (expected_q.size() == 0) begin
            report("response beat with no request pending");
         end else begin
            e = expected_q.pop_front();
            if (h !== e.heading)
               report($sformatf("heading %0h, expected %0h", h, e.heading));
            if (t !== e.tilt)
               report($sformatf("tilt %0h, expected %0h", t, e.tilt));
         end
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic signed [ACCEL_W-1:0] req_accel_x = '0, req_accel_y = '0, req_accel_z = '0;
   logic signed [MAG_W-1:0]   req_mag_x = '0, req_mag_y = '0, req_mag_z = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [HEADING_W-1:0] rsp_heading;
   logic signed [TILT_W-1:0]    rsp_tilt;
   logic csr_wr_en = 0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DECL_W-1:0] csr_wdata = '0;

   heading_scoreboard sb = new();
   int stall_pct = 0;
   int cycles = 0;
   int sent = 0;
   int phases = 0;

   tilt_compensated_compass_heading_core DUT (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   // receiver: check accepted beats, stall on its own random pattern
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_heading, rsp_tilt);
      rsp_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("tilt_compensated_compass_heading_core: mismatch");
         $finish;
      end
   end

   function automatic int srand(int k);
      return int'($urandom_range(0, 2 * k)) - k;
   endfunction

   function automatic sensor_beat_type random_beat();
      sensor_beat_type s;
      int pick;
      pick = $urandom_range(0, 9);
      // mostly near-level gravity with moderate field; some anywhere, some with no x/y tilt or gravity along x only
      s.ax = ACCEL_W'(srand(3000));
      s.ay = ACCEL_W'(srand(3000));
      s.az = ACCEL_W'(4096 + srand(1500));
      s.mx = MAG_W'(srand(2000));
      s.my = MAG_W'(srand(2000));
      s.mz = MAG_W'(srand(2000));
      if ($urandom_range(0, 1)) s.az = -s.az;
      case (pick)
         6, 7: begin
            s.ax = ACCEL_W'($urandom); s.ay = ACCEL_W'($urandom); s.az = ACCEL_W'($urandom);
            s.mx = MAG_W'($urandom); s.my = MAG_W'($urandom); s.mz = MAG_W'($urandom);
         end
         8: begin
            s.ax = '0;
            s.ay = '0;
         end
         9: begin
            s.ay = '0;
            s.az = '0;
            if (s.ax == '0) s.ax = -17'sd65536;
         end
         default: ;
      endcase
      return s;
   endfunction

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [DECL_W-1:0] val);
      @(posedge clock);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 0;
      sb.set_reg(idx, val);
   endtask

   // sender: bursts of beats separated by random gaps
   task automatic send_beats(sensor_beat_type beats[$]);
      int burst;
      burst = 0;
      foreach (beats[i]) begin
         if (burst == 0) begin
            req_valid <= 0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            burst = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 8);
         end
         burst--;
         req_valid <= 1;
         req_accel_x <= beats[i].ax;
         req_accel_y <= beats[i].ay;
         req_accel_z <= beats[i].az;
         req_mag_x <= beats[i].mx;
         req_mag_y <= beats[i].my;
         req_mag_z <= beats[i].mz;
         do @(posedge clock); while (!(req_valid && !req_stall));
         sb.note_request(beats[i]);
         sent++;
      end
      req_valid <= 0;
   endtask

   task automatic drain();
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(logic [DECL_W-1:0] decl, bit accel, bit mag, int n, int stall);
      sensor_beat_type beats[$];
      drain();
      write_reg(CSR_DECLINATION, decl);
      write_reg(CSR_ACCEL_PRESENT, DECL_W'(accel));
      write_reg(CSR_MAG_PRESENT, DECL_W'(mag));
      write_reg(CSR_UNMAPPED, DECL_W'($urandom));
      stall_pct = stall;
      phases++;
      repeat (n) beats.push_back(random_beat());
      send_beats(beats);
   endtask

   function automatic sensor_beat_type mk(int ax, int ay, int az, int mx, int my, int mz);
      sensor_beat_type s;
      s.ax = ACCEL_W'(ax); s.ay = ACCEL_W'(ay); s.az = ACCEL_W'(az);
      s.mx = MAG_W'(mx); s.my = MAG_W'(my); s.mz = MAG_W'(mz);
      return s;
   endfunction

   initial begin
      sensor_beat_type directed[$];
      repeat (9) @(posedge clock);
      reset <= 0;

      // reset register values: no magnetometer, tilt held at its reset value
      directed = '{mk(100, 200, 4096, 300, -400, 500), mk(0, 0, 0, 0, 0, 0)};
      send_beats(directed);

      // directed corners with tilt compensation on
      drain();
      write_reg(CSR_ACCEL_PRESENT, DECL_W'(1));
      write_reg(CSR_MAG_PRESENT, DECL_W'(1));
      phases++;
      directed = '{
         mk(0, 0, 4096, 1000, 0, 0),                    // level, plain path
         mk(0, 0, 0, 0, 0, 0),                          // zero field vector
         mk(4096, 0, 0, 500, 600, 700),                 // gravity along x only
         mk(-65536, 0, 0, -32768, 32767, -32768),
         mk(65535, 65535, 65535, 32767, 32767, 32767),
         mk(-65536, -65536, -65536, -32768, -32768, -32768),
         mk(1, 0, 0, 0, 0, 0),
         mk(0, 1, 0, 0, 1, 0),
         mk(0, -1, -1, -1, 0, 0),
         mk(100, 0, -4096, -1000, -1, 300),
         mk(0, 4096, 0, 0, -1000, 2000),
         mk(-2000, 1500, 3000, 200, -300, 400),
         mk(65535, -65536, 0, 32767, -32768, 0),
         mk(-1, -1, 65535, 0, 0, 32767),
         mk(3000, -3000, -2000, -32768, 0, -1),
         mk(0, 0, 4096, -1000, -1, 0),
         mk(0, 0, 4096, -1000, 0, 0)
      };
      send_beats(directed);

      // random phases across register settings and stall pressure
      run_phase(0, 1, 1, 150, 0);
      run_phase(15'sd11520, 1, 1, 100, 30);
      run_phase(-15'sd11520, 1, 1, 100, 75);
      run_phase(-15'sd16384, 1, 1, 80, 10);
      run_phase(15'sd16383, 0, 1, 80, 50);
      run_phase(-15'sd5000, 0, 1, 80, 0);
      run_phase(15'sd777, 1, 0, 60, 40);
      run_phase(-15'sd1, 0, 0, 40, 20);
      run_phase(15'($urandom_range(0, 23040) - 11520), 1, 1, 150, 60);

      drain();
      if (sb.expected_q.size() != 0)
         sb.report($sformatf("%0d responses never arrived", sb.expected_q.size()));
      $display("sent %0d sensor beats over %0d register settings, %0d responses checked",
               sent, phases, sb.checked);
      if (sb.errors == 0)
         $display("tilt_compensated_compass_heading_core: match");
      else
         $display("tilt_compensated_compass_heading_core: mismatch");
      $finish;
   end

endmodule
